[design/timed_light_switch_assert.svh]
// Assertion macros used by timed_light_switch.
`ifndef TIMED_LIGHT_SWITCH_ASSERT_SVH
`define TIMED_LIGHT_SWITCH_ASSERT_SVH

// same-cycle implication
`define TLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tls_pkg.sv]
`default_nettype none

package tls_pkg;

  localparam int TICK_W           = 16;
  localparam int THR_W            = 8;
  localparam int PERIODS_OUT_W    = 16;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 16;

  localparam int PERIOD_WIDTH_DEF = 16;
  localparam int HOLD_CAP_DEF     = 10000;

  localparam logic [TICK_W-1:0] TICK_RELOAD_RST     = 16'd1000;
  localparam logic [THR_W-1:0]  PRESS_THRESHOLD_RST = 8'd3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RELOAD     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD = 4'd1;

  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_HOLDING     = 2'd1,
    MODE_WAIT_LIGHT  = 2'd2,
    MODE_WAIT_MODIFY = 2'd3
  } mode_e;

  typedef struct packed {
    logic                     relay_on;
    logic [PERIODS_OUT_W-1:0] periods_remaining;
    mode_e                    mode;
  } result_t;

endpackage

`default_nettype wire

[design/tls_hold_counter.sv]
`default_nettype none

module tls_hold_counter #(
  parameter int HOLD_CAP = tls_pkg::HOLD_CAP_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     level_i,
  input  wire logic [tls_pkg::THR_W-1:0] threshold_i,
  output logic                          pressed_o
);
  import tls_pkg::*;

  localparam int HOLD_W = $clog2(HOLD_CAP + 1);
  localparam int CMP_W  = (HOLD_W > THR_W) ? HOLD_W : THR_W;

  logic [HOLD_W-1:0] cnt_q, cnt_d;
  logic [CMP_W-1:0]  cnt_ext, thr_ext;

  always_comb begin
    if (!level_i) begin
      cnt_d = '0;
    end else if (cnt_q >= HOLD_W'(HOLD_CAP)) begin
      cnt_d = HOLD_W'(HOLD_CAP);
    end else begin
      cnt_d = cnt_q + HOLD_W'(1);
    end
  end

  // pressed is judged on the updated count
  assign cnt_ext   = CMP_W'(cnt_d);
  assign thr_ext   = CMP_W'(threshold_i);
  assign pressed_o = cnt_ext > thr_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/tls_ctrl.sv]
`default_nettype none

module tls_ctrl #(
  parameter int PERIOD_WIDTH = tls_pkg::PERIOD_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       light_i,
  input  wire logic                       modify_i,
  input  wire logic [tls_pkg::TICK_W-1:0] tick_reload_i,
  output tls_pkg::result_t                res_o
);
  import tls_pkg::*;

  localparam int EXT_W = PERIOD_WIDTH + PERIODS_OUT_W;

  mode_e                   mode_q, mode_d;
  logic                    lamp_q, lamp_d;
  logic [TICK_W-1:0]       tick_q, tick_d;
  logic [PERIOD_WIDTH-1:0] periods_q, periods_d;
  logic [PERIOD_WIDTH-1:0] periods_dbl;
  logic [EXT_W-1:0]        periods_ext;

  // saturating doubling: top bit set means the double overflows
  assign periods_dbl = periods_q[PERIOD_WIDTH-1] ? '1 : {periods_q[PERIOD_WIDTH-2:0], 1'b0};

  // next mode
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (light_i) begin
          mode_d = lamp_q ? MODE_WAIT_LIGHT : MODE_HOLDING;
        end
      end
      MODE_HOLDING: begin
        if (modify_i) begin
          mode_d = MODE_WAIT_MODIFY;
        end else if (!light_i) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_WAIT_LIGHT: begin
        if (!light_i) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_WAIT_MODIFY: begin
        if (!modify_i) begin
          mode_d = light_i ? MODE_HOLDING : MODE_NORMAL;
        end
      end
      default: mode_d = MODE_NORMAL;
    endcase
  end

  // lamp and countdown
  always_comb begin
    lamp_d    = lamp_q;
    tick_d    = tick_q;
    periods_d = periods_q;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (light_i) begin
          if (lamp_q) begin
            lamp_d = 1'b0;
          end else begin
            lamp_d    = 1'b1;
            tick_d    = tick_reload_i;
            periods_d = PERIOD_WIDTH'(1);
          end
        end else if (lamp_q) begin
          if (tick_q > TICK_W'(1)) begin
            tick_d = tick_q - TICK_W'(1);
          end else if (periods_q > PERIOD_WIDTH'(1)) begin
            periods_d = periods_q - PERIOD_WIDTH'(1);
            tick_d    = tick_reload_i;
          end else begin
            lamp_d    = 1'b0;
            periods_d = '0;
            tick_d    = '0;
          end
        end
      end
      MODE_HOLDING: begin
        if (modify_i) begin
          periods_d = periods_dbl;
        end
      end
      MODE_WAIT_LIGHT, MODE_WAIT_MODIFY: begin
      end
      default: begin
      end
    endcase
  end

  assign periods_ext             = EXT_W'(periods_d);
  assign res_o.relay_on          = lamp_d;
  assign res_o.periods_remaining = periods_ext[PERIODS_OUT_W-1:0];
  assign res_o.mode              = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      lamp_q    <= 1'b0;
      tick_q    <= '0;
      periods_q <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      lamp_q    <= lamp_d;
      tick_q    <= tick_d;
      periods_q <= periods_d;
    end
  end

endmodule

`default_nettype wire

[design/timed_light_switch.sv]
// Staircase light timer. Each input item is one poll tick with both button
// levels and gives exactly one result item: relay drive, periods left and mode,
// as they stand after that tick. An item passes an input register and is worked
// combinationally into the output register, from which its result is taken. One
// item per cycle is taken for as long as the output side is not stalled; with
// both registers full the input is stalled until the result is taken. The
// config port is always ready.
`default_nettype none

`include "timed_light_switch_assert.svh"

module timed_light_switch #(
  parameter int PERIOD_WIDTH = tls_pkg::PERIOD_WIDTH_DEF,
  parameter int HOLD_CAP     = tls_pkg::HOLD_CAP_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              light_pressed_i,
  input  wire logic                              modify_pressed_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   relay_on_o,
  output logic [tls_pkg::PERIODS_OUT_W-1:0]      periods_remaining_o,
  output logic [1:0]                             current_mode_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tls_pkg::*;

  logic              in_vld_q;
  logic              light_q, modify_q;
  logic              out_vld_q;
  result_t           res_q, res_d;
  logic              advance;
  logic              light_prs, modify_prs;
  logic [TICK_W-1:0] tick_reload_q;
  logic [THR_W-1:0]  threshold_q;

  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_reload_q <= TICK_RELOAD_RST;
      threshold_q   <= PRESS_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TICK_RELOAD) begin
        tick_reload_q <= cfg_data_i[TICK_W-1:0];
      end else if (cfg_index_i == CFG_PRESS_THRESHOLD) begin
        threshold_q <= cfg_data_i[THR_W-1:0];
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      light_q  <= light_pressed_i;
      modify_q <= modify_pressed_i;
    end
  end

  tls_hold_counter #(
    .HOLD_CAP (HOLD_CAP)
  ) u_light_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .level_i     (light_q),
    .threshold_i (threshold_q),
    .pressed_o   (light_prs)
  );

  tls_hold_counter #(
    .HOLD_CAP (HOLD_CAP)
  ) u_modify_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .level_i     (modify_q),
    .threshold_i (threshold_q),
    .pressed_o   (modify_prs)
  );

  tls_ctrl #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .light_i       (light_prs),
    .modify_i      (modify_prs),
    .tick_reload_i (tick_reload_q),
    .res_o         (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign relay_on_o          = res_q.relay_on;
  assign periods_remaining_o = res_q.periods_remaining;
  assign current_mode_o      = res_q.mode;

  `TLS_ASSERT_NOW(a_lamp_on_in_holding, clk_i, rst_ni,
    out_vld_q && (res_q.mode == MODE_HOLDING || res_q.mode == MODE_WAIT_MODIFY),
    res_q.relay_on, "lamp off while holding after switch-on")
  `TLS_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni,
    advance, out_vld_q, "worked item did not reach the output register")
  `TLS_ASSERT_NEXT(a_stalled_item_kept, clk_i, rst_ni,
    in_stall_o, in_vld_q, "stalled item lost from the input register")

endmodule

`default_nettype wire
